@@ sv/pcc_pkg.sv @@
// shared types, constants and the channel pair lookup for the coincidence counter
package pcc_pkg;

  localparam int TS_W       = 32;
  localparam int CH_W       = 3;
  localparam int DLY_W      = 21;
  localparam int WIN_W      = 20;
  localparam int TIME_W     = 34;
  localparam int DIFF_W     = 35;
  localparam int CNT_W      = 32;
  localparam int NPAIR      = 6;
  localparam int NDLY       = 4;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int STAT_W     = 2;
  localparam int QDEPTH     = 4;
  localparam int QAW        = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DELAY_CH0 = 3'd0;
  localparam cfg_idx_t CFG_DELAY_CH1 = 3'd1;
  localparam cfg_idx_t CFG_DELAY_CH2 = 3'd2;
  localparam cfg_idx_t CFG_DELAY_CH3 = 3'd3;
  localparam cfg_idx_t CFG_WINDOW    = 3'd4;

  typedef logic [STAT_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_SHORT = 2'd1;
  localparam status_t ST_DROP  = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] dtime;
    logic [CH_W-1:0]   chan;
    logic              last;
  } event_t;

  typedef struct packed {
    logic [TIME_W-1:0] dtime;
    logic [CH_W-1:0]   chan;
  } store_t;

  typedef struct packed {
    logic              hit_ok;
    logic [SLOT_W-1:0] idx;
  } slot_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_RD_I,
    BK_GET_I,
    BK_SCAN,
    BK_DRAIN,
    BK_OUT
  } back_state_t;

  function automatic slot_t pair_slot(input logic [CH_W-1:0] ca, input logic [CH_W-1:0] cb);
    slot_t s;
    s.hit_ok = 1'b0;
    s.idx    = '0;
    if (!ca[2] && !cb[2] && (ca != cb)) begin
      s.hit_ok = 1'b1;
      case ({ca[1:0], cb[1:0]})
        4'b0001, 4'b0100: s.idx = 3'd0;
        4'b0010, 4'b1000: s.idx = 3'd1;
        4'b0011, 4'b1100: s.idx = 3'd2;
        4'b0110, 4'b1001: s.idx = 3'd3;
        4'b0111, 4'b1101: s.idx = 3'd4;
        4'b1011, 4'b1110: s.idx = 3'd5;
        default:          s.hit_ok = 1'b0;
      endcase
    end
    return s;
  endfunction

endpackage

@@ sv/pcc_front.sv @@
// front end: configuration registers, word intake and per-channel delay
module pcc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pcc_pkg::TS_W-1:0]   in_timestamp,
  input  logic [pcc_pkg::CH_W-1:0]          in_event_channel,
  input  logic                              in_last_event,
  input  logic                              q_full,
  output logic                              q_push,
  output pcc_pkg::event_t                   q_wdata,
  output logic [pcc_pkg::WIN_W-1:0]         window
);

  logic [pcc_pkg::DLY_W-1:0]  dly_r [pcc_pkg::NDLY];
  logic [pcc_pkg::WIN_W-1:0]  win_r;
  logic [pcc_pkg::DLY_W-1:0]  dly_sel;

  assign cfg_ready = 1'b1;
  assign window    = win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < pcc_pkg::NDLY; k++) begin
        dly_r[k] <= '0;
      end
      win_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcc_pkg::CFG_DELAY_CH0: dly_r[0] <= cfg_data;
        pcc_pkg::CFG_DELAY_CH1: dly_r[1] <= cfg_data;
        pcc_pkg::CFG_DELAY_CH2: dly_r[2] <= cfg_data;
        pcc_pkg::CFG_DELAY_CH3: dly_r[3] <= cfg_data;
        pcc_pkg::CFG_WINDOW:    win_r    <= cfg_data[pcc_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // channels 4 to 7 take no delay
  assign dly_sel  = in_event_channel[2] ? '0 : dly_r[in_event_channel[1:0]];
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata.dtime = {{(pcc_pkg::TIME_W-pcc_pkg::TS_W){in_timestamp[pcc_pkg::TS_W-1]}},
                     in_timestamp}
                  + {{(pcc_pkg::TIME_W-pcc_pkg::DLY_W){dly_sel[pcc_pkg::DLY_W-1]}}, dly_sel};
    q_wdata.chan  = in_event_channel;
    q_wdata.last  = in_last_event;
  end

endmodule

@@ sv/pcc_queue.sv @@
// short word queue between the front end and the pair scanner
module pcc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pcc_pkg::event_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output pcc_pkg::event_t rdata
);

  pcc_pkg::event_t           entry_r [pcc_pkg::QDEPTH];
  logic [pcc_pkg::QAW-1:0]   wr_ptr_r;
  logic [pcc_pkg::QAW-1:0]   rd_ptr_r;
  logic [pcc_pkg::QAW:0]     cnt_r;
  logic [pcc_pkg::QAW:0]     cnt_nxt;

  assign full  = (cnt_r == (pcc_pkg::QAW+1)'(pcc_pkg::QDEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = entry_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ sv/pcc_back.sv @@
// back end: event store, pair scan sequencer and the six pair counters
module pcc_back #(
  parameter int MAX_EVENTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  pcc_pkg::event_t                q_rdata,
  output logic                           q_pop,
  input  logic [pcc_pkg::WIN_W-1:0]      window,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pcc_pkg::CNT_W-1:0]      cnt [pcc_pkg::NPAIR],
  output pcc_pkg::status_t               status
);

  localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CW = $clog2(MAX_EVENTS + 1);

  pcc_pkg::store_t               mem [MAX_EVENTS];
  pcc_pkg::store_t               rd_data_r;
  pcc_pkg::store_t               mem_wdata;
  logic                          mem_we;
  logic [AW-1:0]                 rd_addr;

  pcc_pkg::back_state_t          state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          ovf_r, ovf_nxt;
  pcc_pkg::status_t              status_r, status_nxt;
  logic [AW-1:0]                 i_r, i_nxt;
  logic [AW-1:0]                 j_r, j_nxt;
  logic [pcc_pkg::TIME_W-1:0]    ti_r, ti_nxt;
  logic [pcc_pkg::CH_W-1:0]      ci_r, ci_nxt;
  logic                          store_full;
  logic                          more_i;
  logic                          scan_rd;

  logic                          a_valid_r;
  logic                          b_valid_r;
  logic signed [pcc_pkg::DIFF_W-1:0] diff_r;
  logic [pcc_pkg::SLOT_W-1:0]    slot_r;
  pcc_pkg::slot_t                slot;
  logic signed [pcc_pkg::DIFF_W-1:0] win_s;
  logic signed [pcc_pkg::DIFF_W-1:0] win_neg;
  logic                          hit;
  logic [pcc_pkg::CNT_W-1:0]     cnt_r [pcc_pkg::NPAIR];

  assign store_full = (count_r == CW'(MAX_EVENTS));
  assign more_i     = ((CW'(i_r) + CW'(2)) < count_r);
  assign mem_wdata.dtime = q_rdata.dtime;
  assign mem_wdata.chan  = q_rdata.chan;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    status_nxt = status_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ti_nxt     = ti_r;
    ci_nxt     = ci_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    rd_addr    = i_r;
    scan_rd    = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      pcc_pkg::BK_LOAD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (store_full) begin
            ovf_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (q_rdata.last) begin
            i_nxt = '0;
            if (count_nxt < CW'(2)) begin
              status_nxt = pcc_pkg::ST_SHORT;
              state_nxt  = pcc_pkg::BK_OUT;
            end else begin
              status_nxt = ovf_nxt ? pcc_pkg::ST_DROP : pcc_pkg::ST_OK;
              state_nxt  = pcc_pkg::BK_RD_I;
            end
          end
        end
      end
      pcc_pkg::BK_RD_I: begin
        rd_addr   = i_r;
        state_nxt = pcc_pkg::BK_GET_I;
      end
      pcc_pkg::BK_GET_I: begin
        ti_nxt = rd_data_r.dtime;
        ci_nxt = rd_data_r.chan;
        if (!rd_data_r.chan[2]) begin
          j_nxt     = i_r + 1'b1;
          state_nxt = pcc_pkg::BK_SCAN;
        end else if (more_i) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = pcc_pkg::BK_RD_I;
        end else begin
          state_nxt = pcc_pkg::BK_DRAIN;
        end
      end
      pcc_pkg::BK_SCAN: begin
        rd_addr = j_r;
        scan_rd = 1'b1;
        if ((CW'(j_r) + 1'b1) == count_r) begin
          if (more_i) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = pcc_pkg::BK_RD_I;
          end else begin
            state_nxt = pcc_pkg::BK_DRAIN;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      pcc_pkg::BK_DRAIN: begin
        if (!a_valid_r && !b_valid_r) begin
          state_nxt = pcc_pkg::BK_OUT;
        end
      end
      pcc_pkg::BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = pcc_pkg::BK_LOAD;
        end
      end
      default: begin
        state_nxt = pcc_pkg::BK_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pcc_pkg::BK_LOAD;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      status_r <= pcc_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    ti_r <= ti_nxt;
    ci_r <= ci_nxt;
  end

  // event store, one write port and one read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // compare stage
  assign slot = pcc_pkg::pair_slot(ci_r, rd_data_r.chan);

  always_ff @(posedge clk) begin
    diff_r <= $signed({rd_data_r.dtime[pcc_pkg::TIME_W-1], rd_data_r.dtime})
            - $signed({ti_r[pcc_pkg::TIME_W-1], ti_r});
    slot_r <= slot.idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= scan_rd;
      b_valid_r <= a_valid_r && slot.hit_ok;
    end
  end

  // count stage
  assign win_s   = $signed({{(pcc_pkg::DIFF_W-pcc_pkg::WIN_W){1'b0}}, window});
  assign win_neg = -win_s;
  assign hit     = (diff_r <= win_s) && (diff_r >= win_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < pcc_pkg::NPAIR; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < pcc_pkg::NPAIR; k++) begin
        if (b_valid_r && hit && (slot_r == pcc_pkg::SLOT_W'(k))) begin
          cnt_r[k] <= cnt_r[k] + 1'b1;
        end
      end
    end
  end

  assign cnt    = cnt_r;
  assign status = status_r;

endmodule

@@ sv/pairwise_coincidence_counter.sv @@
// top level: pairwise coincidence counter over batches of time-tagged events
// loading: one word per cycle into a 4-word queue while it is not full
// scan: after the last word, stored pairs are compared one per cycle while a row is scanned,
//   through the single read port of the event store
// next batch loads only once the result is taken; 1024 events max, later ones dropped
// reset: synchronous active-low rst_n clears control state, counters and queue; not the store
module pairwise_coincidence_counter #(
  parameter int MAX_EVENTS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pcc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pcc_pkg::TS_W-1:0]     in_timestamp,
  input  logic [pcc_pkg::CH_W-1:0]            in_event_channel,
  input  logic                                in_last_event,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pcc_pkg::CNT_W-1:0]           out_count_0_1,
  output logic [pcc_pkg::CNT_W-1:0]           out_count_0_2,
  output logic [pcc_pkg::CNT_W-1:0]           out_count_0_3,
  output logic [pcc_pkg::CNT_W-1:0]           out_count_1_2,
  output logic [pcc_pkg::CNT_W-1:0]           out_count_1_3,
  output logic [pcc_pkg::CNT_W-1:0]           out_count_2_3,
  output logic [pcc_pkg::STAT_W-1:0]          out_batch_status
);

  logic                          q_full;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_valid;
  pcc_pkg::event_t               q_wdata;
  pcc_pkg::event_t               q_rdata;
  logic [pcc_pkg::WIN_W-1:0]     window;
  logic [pcc_pkg::CNT_W-1:0]     cnt [pcc_pkg::NPAIR];
  pcc_pkg::status_t              status;

  pcc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_timestamp     (in_timestamp),
    .in_event_channel (in_event_channel),
    .in_last_event    (in_last_event),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_wdata          (q_wdata),
    .window           (window)
  );

  pcc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  pcc_back #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .window    (window),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cnt       (cnt),
    .status    (status)
  );

  assign out_count_0_1    = cnt[0];
  assign out_count_0_2    = cnt[1];
  assign out_count_0_3    = cnt[2];
  assign out_count_1_2    = cnt[3];
  assign out_count_1_3    = cnt[4];
  assign out_count_2_3    = cnt[5];
  assign out_batch_status = status;

  // queue never popped while empty
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a counter moves by at most one per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((out_count_0_1 == $past(out_count_0_1)) ||
                      (out_count_0_1 == $past(out_count_0_1) + 1'b1)))
    else $error("count_0_1 jumped");

  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((out_count_2_3 == $past(out_count_2_3)) ||
                      (out_count_2_3 == $past(out_count_2_3) + 1'b1)))
    else $error("count_2_3 jumped");

  // counters hold while a result is shown
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && $past(rst_n)) |-> $stable(out_count_1_2))
    else $error("counter moved during result");

  // a taken result needs a new batch before the next one
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated");

endmodule

@@ tb/pairwise_coincidence_counter_tb.sv @@
// self-checking testbench for the pairwise coincidence counter with its own pair-count predictor
module pairwise_coincidence_counter_tb;
  import pcc_pkg::*;

  localparam int MAX_EV     = 1024;
  localparam int IDLE_LIMIT = 2_000_000;
  localparam int CFG_SETTLE = 8;
  localparam int END_SETTLE = 50;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 800;
  localparam int NPHASE     = 6;

  localparam longint TS_MAX  = 64'sd2147483647;
  localparam longint TS_MIN  = -64'sd2147483648;
  localparam longint DLY_MAX = (longint'(1) << (DLY_W - 1)) - 1;
  localparam longint DLY_MIN = -(longint'(1) << (DLY_W - 1));
  localparam longint WIN_MAX = (longint'(1) << WIN_W) - 1;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic [NPAIR-1:0][CNT_W-1:0] cnt;
    status_t                     status;
  } tally_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [TS_W-1:0] in_timestamp = '0;
  logic [CH_W-1:0]        in_event_channel = '0;
  logic                   in_last_event = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CNT_W-1:0]       out_count_0_1;
  logic [CNT_W-1:0]       out_count_0_2;
  logic [CNT_W-1:0]       out_count_0_3;
  logic [CNT_W-1:0]       out_count_1_2;
  logic [CNT_W-1:0]       out_count_1_3;
  logic [CNT_W-1:0]       out_count_2_3;
  logic [STAT_W-1:0]      out_batch_status;

  logic signed [DLY_W-1:0] dly_model [NDLY];
  logic [WIN_W-1:0]        window_model;
  longint                  held_time [MAX_EV];
  logic [CH_W-1:0]         held_chan [MAX_EV];
  int                      held_count;
  bit                      dropped_any;
  logic [CNT_W-1:0]        pair_tally [NPAIR];
  tally_t                  pending_tallies [$];
  int                      errors;
  int                      stuck_cycles;

  bit       gaps_on;
  int       burst_left;
  rx_mode_t rx_mode = RX_ALWAYS;
  bit       hold_req;

  pairwise_coincidence_counter #(.MAX_EVENTS(MAX_EV)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_timestamp     (in_timestamp),
    .in_event_channel (in_event_channel),
    .in_last_event    (in_last_event),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_count_0_1    (out_count_0_1),
    .out_count_0_2    (out_count_0_2),
    .out_count_0_3    (out_count_0_3),
    .out_count_1_2    (out_count_1_2),
    .out_count_1_3    (out_count_1_3),
    .out_count_2_3    (out_count_2_3),
    .out_batch_status (out_batch_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pair_index(int a, int b);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return lo * (7 - lo) / 2 + hi - lo - 1;
  endfunction

  function automatic void tally_event(logic signed [TS_W-1:0] ts, logic [CH_W-1:0] ch,
                                      logic last);
    longint t;
    longint d;
    tally_t want;
    t = longint'(ts);
    if (ch < NDLY) t = t + longint'(dly_model[ch]);
    if (held_count < MAX_EV) begin
      held_time[held_count] = t;
      held_chan[held_count] = ch;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!last) return;
    if (held_count < 2) begin
      want.status = ST_SHORT;
    end else begin
      want.status = dropped_any ? ST_DROP : ST_OK;
      for (int i = 0; i < held_count - 1; i++) begin
        if (held_chan[i] >= NDLY) continue;
        for (int j = i + 1; j < held_count; j++) begin
          if (held_chan[j] >= NDLY || held_chan[j] == held_chan[i]) continue;
          d = held_time[j] - held_time[i];
          if (d < 0) d = -d;
          if (d <= longint'(window_model))
            pair_tally[pair_index(held_chan[i], held_chan[j])]++;
        end
      end
    end
    for (int k = 0; k < NPAIR; k++) want.cnt[k] = pair_tally[k];
    pending_tallies.push_back(want);
    held_count  = 0;
    dropped_any = 1'b0;
  endfunction

  function automatic longint rand_delay();
    return longint'($urandom_range(0, (1 << DLY_W) - 1)) + DLY_MIN;
  endfunction

  task automatic send_word(logic signed [TS_W-1:0] ts, logic [CH_W-1:0] ch, logic last);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid         <= 1'b1;
    in_timestamp     <= ts;
    in_event_channel <= ch;
    in_last_event    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tally_event(ts, ch, last);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NDLY) dly_model[idx] = data;
    else if (idx == CFG_WINDOW) window_model = data[WIN_W-1:0];
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic set_config(longint d0, longint d1, longint d2, longint d3, longint win);
    logic [CFG_DATA_W-1:0] wdata;
    wait_idle();
    wdata = CFG_DATA_W'($urandom);
    wdata[WIN_W-1:0] = win[WIN_W-1:0];
    write_reg(CFG_DELAY_CH0, d0[CFG_DATA_W-1:0]);
    write_reg(CFG_DELAY_CH1, d1[CFG_DATA_W-1:0]);
    write_reg(CFG_DELAY_CH2, d2[CFG_DATA_W-1:0]);
    write_reg(CFG_DELAY_CH3, d3[CFG_DATA_W-1:0]);
    write_reg(CFG_WINDOW, wdata);
    cfg_valid <= 1'b0;
  endtask

  // with tidy set, events cluster around one delayed time so that coincidences happen; else random
  task automatic run_batch(int n, bit tidy);
    longint          center;
    longint          t;
    int              spread;
    logic [CH_W-1:0] ch;
    center = longint'($signed($urandom));
    spread = 2 * int'(window_model) + 4;
    for (int e = 0; e < n; e++) begin
      if (tidy) begin
        if ($urandom_range(0, 9) < 8) ch = CH_W'($urandom_range(0, NDLY - 1));
        else ch = CH_W'($urandom_range(NDLY, 7));
        t = center + longint'($urandom_range(0, spread)) - spread / 2;
        if (ch < NDLY) t = t - longint'(dly_model[ch]);
        if (t > TS_MAX) t = TS_MAX;
        if (t < TS_MIN) t = TS_MIN;
      end else begin
        ch = CH_W'($urandom);
        t  = longint'($signed($urandom));
      end
      send_word(t[TS_W-1:0], ch, e == n - 1);
    end
  endtask

  task automatic test_directed_defaults();
    send_word(0, 0, 1'b1);
    send_word(100, 0, 1'b0);
    send_word(100, 1, 1'b0);
    send_word(100, 2, 1'b0);
    send_word(100, 3, 1'b0);
    send_word(100, 0, 1'b0);
    send_word(100, 4, 1'b0);
    send_word(101, 1, 1'b1);
    send_word(TS_MAX, 2, 1'b0);
    send_word(TS_MIN, 3, 1'b0);
    send_word(TS_MAX, 3, 1'b0);
    send_word(TS_MIN, 5, 1'b1);
    send_word(5, 4, 1'b0);
    send_word(5, 5, 1'b0);
    send_word(5, 7, 1'b1);
    send_word(-1, 6, 1'b1);
  endtask

  task automatic test_delay_extremes();
    set_config(DLY_MIN, DLY_MAX, 0, -1, WIN_MAX);
    send_word(TS_MAX, 0, 1'b0);
    send_word(TS_MAX - 64'sd1048576, 1, 1'b1);
    send_word(TS_MAX, 0, 1'b0);
    send_word(TS_MAX - 64'sd1048575, 1, 1'b1);
    send_word(TS_MIN, 0, 1'b0);
    send_word(TS_MIN, 3, 1'b0);
    send_word(TS_MAX, 1, 1'b0);
    send_word(TS_MIN, 2, 1'b1);
    set_config(DLY_MAX, DLY_MIN, DLY_MAX, DLY_MIN, 0);
    send_word(TS_MAX, 0, 1'b0);
    send_word(TS_MAX, 2, 1'b0);
    send_word(TS_MIN, 1, 1'b0);
    send_word(TS_MIN, 3, 1'b1);
  endtask

  task automatic test_unused_regs();
    wait_idle();
    for (int k = int'(CFG_WINDOW) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(cfg_idx_t'(k), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    run_batch(6, 1'b1);
    run_batch(9, 1'b1);
  endtask

  task automatic test_store_overflow();
    set_config(rand_delay(), rand_delay(), rand_delay(), rand_delay(), 4096);
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    run_batch(MAX_EV + 1, 1'b1);
  endtask

  task automatic test_backpressure();
    set_config(rand_delay(), rand_delay(), rand_delay(), rand_delay(), 300);
    gaps_on  = 1'b0;
    rx_mode  = RX_ALWAYS;
    hold_req = 1'b1;
    for (int b = 0; b < 10; b++) run_batch(4, 1'b1);
    wait_idle();
    run_batch(5, 1'b1);
    run_batch(3, 1'b1);
  endtask

  task automatic test_random_phases();
    int sent;
    int n;
    int pick;
    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        1: set_config(DLY_MAX, DLY_MAX, DLY_MAX, DLY_MAX, WIN_MAX);
        2: set_config(DLY_MIN, DLY_MIN, DLY_MIN, DLY_MIN, 0);
        3: set_config(rand_delay(), rand_delay(), rand_delay(), rand_delay(),
                      $urandom_range(0, WIN_MAX));
        default: set_config(rand_delay(), rand_delay(), rand_delay(), rand_delay(),
                            $urandom_range(0, 200));
      endcase
      gaps_on = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_mode = (p == 0) ? RX_ALWAYS : rx_mode_t'($urandom_range(0, 3));
      sent = 0;
      while (sent < RAND_ITEMS / NPHASE) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) begin
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
          run_batch(n, 1'b1);
        end else if (pick < 18) begin
          n = 1;
          run_batch(n, $urandom_range(0, 1));
        end else begin
          n = $urandom_range(1, 8);
          run_batch(n, 1'b0);
        end
        sent += n;
      end
    end
  endtask

  initial begin : receiver
    int phase_cnt;
    phase_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end
      phase_cnt++;
      case (rx_mode)
        RX_ALWAYS:   out_ready <= 1'b1;
        RX_RANDOM:   out_ready <= $urandom_range(0, 1);
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ready <= ((phase_cnt % 16) >= 5);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin : tally_check
    tally_t                      want;
    logic [NPAIR-1:0][CNT_W-1:0] got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_count_2_3, out_count_1_3, out_count_1_2,
             out_count_0_3, out_count_0_2, out_count_0_1};
      if (pending_tallies.size() == 0) begin
        errors++;
        if (errors < 40)
          $display("%0t: unexpected word, counts %h status %0d", $time, got, out_batch_status);
      end else begin
        want = pending_tallies.pop_front();
        for (int k = 0; k < NPAIR; k++) begin
          if (got[k] !== want.cnt[k]) begin
            errors++;
            if (errors < 40)
              $display("%0t: pair count %0d expected %0d got %0d",
                       $time, k, want.cnt[k], got[k]);
          end
        end
        if (out_batch_status !== want.status) begin
          errors++;
          if (errors < 40)
            $display("%0t: batch status expected %0d got %0d",
                     $time, want.status, out_batch_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    for (int k = 0; k < NDLY; k++) dly_model[k] = '0;
    for (int k = 0; k < NPAIR; k++) pair_tally[k] = '0;
    window_model = '0;
    held_count   = 0;
    dropped_any  = 1'b0;
    errors       = 0;
    stuck_cycles = 0;
    gaps_on      = 1'b0;
    burst_left   = 0;
    hold_req     = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_delay_extremes();
    test_unused_regs();
    test_store_overflow();
    test_backpressure();
    test_random_phases();
    in_valid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pcc_pkg.sv
sv/pcc_front.sv
sv/pcc_queue.sv
sv/pcc_back.sv
sv/pairwise_coincidence_counter.sv
tb/pairwise_coincidence_counter_tb.sv
